>>> hdl/tracker_health_supervisor_core_assert.svh
// Assertion macros for the tracker health supervisor.
// Every macro samples on the rising edge of clk.
// THS_ASSERT is disabled while rst is high. THS_ASSERT_ALWAYS also checks during reset.
`ifndef TRACKER_HEALTH_SUPERVISOR_CORE_ASSERT_SVH
`define TRACKER_HEALTH_SUPERVISOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define THS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define THS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define THS_ASSERT(lbl, prop, msg)
`define THS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/ths_pkg.sv
package ths_pkg;

  localparam int FEATURE_BITS = 12;
  localparam int RUN_BITS     = 8;
  localparam int THR_BITS     = 8;
  localparam int EIGEN_BITS   = 32;
  localparam int STALE_BITS   = 16;
  localparam int HEALTH_BITS  = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CMP_BITS     = (RUN_BITS > THR_BITS) ? RUN_BITS : THR_BITS;

  // Health codes.
  localparam logic [HEALTH_BITS-1:0] HEALTH_WARMUP     = 3'd0;
  localparam logic [HEALTH_BITS-1:0] HEALTH_ACTIVE     = 3'd1;
  localparam logic [HEALTH_BITS-1:0] HEALTH_DEGRADED   = 3'd2;
  localparam logic [HEALTH_BITS-1:0] HEALTH_BYPASS     = 3'd3;
  localparam logic [HEALTH_BITS-1:0] HEALTH_RECOVERING = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_FEATURE_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STARVE_FEATURE_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS_FRAMES          = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVERY_FRAMES_NEEDED = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS_FRAMES      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEGRADE_EIGEN_FLOOR    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS_EIGEN_FLOOR     = 3'd6;

  localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;
  localparam logic [STALE_BITS-1:0] STALE_MAX = '1;

  typedef struct packed {
    logic [FEATURE_BITS-1:0] active_feature_floor;
    logic [FEATURE_BITS-1:0] starve_feature_floor;
    logic [THR_BITS-1:0]     bypass_frames;
    logic [THR_BITS-1:0]     recovery_frames_needed;
    logic [THR_BITS-1:0]     hysteresis_frames;
    logic [EIGEN_BITS-1:0]   degrade_eigen_floor;
    logic [EIGEN_BITS-1:0]   bypass_eigen_floor;
  } ths_cfg_t;

  typedef struct packed {
    logic                    frame_stale;
    logic [FEATURE_BITS-1:0] feature_count;
    logic                    solver_ok;
    logic                    state_nonfinite;
    logic [FEATURE_BITS-1:0] inlier_count;
    logic [EIGEN_BITS-1:0]   min_eigen;
  } ths_frame_t;

  typedef struct packed {
    logic [HEALTH_BITS-1:0] health;
    logic                   run_backend;
    logic                   restart_estimator;
    logic                   dropped_stale;
    logic [STALE_BITS-1:0]  stale_total;
  } ths_result_t;

  function automatic logic [RUN_BITS-1:0] run_inc(input logic [RUN_BITS-1:0] v);
    return (v == RUN_MAX) ? v : RUN_BITS'(v + 1'b1);
  endfunction

  // A threshold above the counter's saturation value is never reached.
  function automatic logic run_ge(input logic [RUN_BITS-1:0] run,
                                  input logic [THR_BITS-1:0] thr);
    return CMP_BITS'(run) >= CMP_BITS'(thr);
  endfunction

endpackage

>>> hdl/ths_in_if.sv
interface ths_in_if
  import ths_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    frame_stale;
  logic [FEATURE_BITS-1:0] feature_count;
  logic                    solver_ok;
  logic                    state_nonfinite;
  logic [FEATURE_BITS-1:0] inlier_count;
  logic [EIGEN_BITS-1:0]   min_eigen;

  modport source (output valid, frame_stale, feature_count, solver_ok, state_nonfinite,
                  inlier_count, min_eigen, input ready);
  modport sink (input valid, frame_stale, feature_count, solver_ok, state_nonfinite,
                inlier_count, min_eigen, output ready);
endinterface

>>> hdl/ths_out_if.sv
interface ths_out_if
  import ths_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [HEALTH_BITS-1:0] health;
  logic                   run_backend;
  logic                   restart_estimator;
  logic                   dropped_stale;
  logic [STALE_BITS-1:0]  stale_total;

  modport source (output valid, health, run_backend, restart_estimator, dropped_stale,
                  stale_total, input ready);
  modport sink (input valid, health, run_backend, restart_estimator, dropped_stale,
                stale_total, output ready);
endinterface

>>> hdl/ths_cfg_if.sv
interface ths_cfg_if
  import ths_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/ths_cfg_regs.sv
module ths_cfg_regs
  import ths_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  ths_cfg_if.sink        cfg,
  output ths_cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.active_feature_floor   <= FEATURE_BITS'(30);
      regs.starve_feature_floor   <= FEATURE_BITS'(10);
      regs.bypass_frames          <= THR_BITS'(3);
      regs.recovery_frames_needed <= THR_BITS'(5);
      regs.hysteresis_frames      <= THR_BITS'(3);
      regs.degrade_eigen_floor    <= EIGEN_BITS'(65536);
      regs.bypass_eigen_floor     <= EIGEN_BITS'(6554);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ACTIVE_FEATURE_FLOOR:   regs.active_feature_floor <= cfg.data[FEATURE_BITS-1:0];
        REG_STARVE_FEATURE_FLOOR:   regs.starve_feature_floor <= cfg.data[FEATURE_BITS-1:0];
        REG_BYPASS_FRAMES:          regs.bypass_frames <= cfg.data[THR_BITS-1:0];
        REG_RECOVERY_FRAMES_NEEDED: regs.recovery_frames_needed <= cfg.data[THR_BITS-1:0];
        REG_HYSTERESIS_FRAMES:      regs.hysteresis_frames <= cfg.data[THR_BITS-1:0];
        REG_DEGRADE_EIGEN_FLOOR:    regs.degrade_eigen_floor <= cfg.data[EIGEN_BITS-1:0];
        REG_BYPASS_EIGEN_FLOOR:     regs.bypass_eigen_floor <= cfg.data[EIGEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/ths_supervisor.sv
module ths_supervisor
  import ths_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ths_cfg_t    regs,
  input  ths_frame_t  frame_in,
  input  logic        commit,
  output ths_result_t result_next
);

  logic [HEALTH_BITS-1:0] health_state, health_state_next;
  logic [RUN_BITS-1:0]    starve_run, starve_run_next;
  logic [RUN_BITS-1:0]    recover_run, recover_run_next;
  logic [RUN_BITS-1:0]    degraded_run, degraded_run_next;
  logic [RUN_BITS-1:0]    healthy_run, healthy_run_next;
  logic [STALE_BITS-1:0]  stale_counter, stale_counter_next;

  logic [RUN_BITS-1:0] starve_inc, recover_inc, degraded_inc, healthy_inc;
  logic                starving, well_fed, low_inliers, eig_degraded, eig_bypass;

  assign starve_inc   = run_inc(starve_run);
  assign recover_inc  = run_inc(recover_run);
  assign degraded_inc = run_inc(degraded_run);
  assign healthy_inc  = run_inc(healthy_run);

  assign starving     = frame_in.feature_count < regs.starve_feature_floor;
  assign well_fed     = frame_in.feature_count >= regs.active_feature_floor;
  assign low_inliers  = frame_in.inlier_count < regs.active_feature_floor;
  assign eig_degraded = frame_in.min_eigen < regs.degrade_eigen_floor;
  assign eig_bypass   = frame_in.min_eigen < regs.bypass_eigen_floor;

  always_comb begin
    health_state_next  = health_state;
    starve_run_next    = starve_run;
    recover_run_next   = recover_run;
    degraded_run_next  = degraded_run;
    healthy_run_next   = healthy_run;
    stale_counter_next = stale_counter;
    result_next.run_backend       = 1'b0;
    result_next.restart_estimator = 1'b0;
    result_next.dropped_stale     = 1'b0;

    if (frame_in.frame_stale) begin
      if (stale_counter != STALE_MAX) begin
        stale_counter_next = STALE_BITS'(stale_counter + 1'b1);
      end
      result_next.dropped_stale = 1'b1;
    end else if (health_state == HEALTH_BYPASS) begin
      if (well_fed) begin
        recover_run_next = recover_inc;
        if (run_ge(recover_inc, regs.recovery_frames_needed)) begin
          result_next.restart_estimator = 1'b1;
          health_state_next = HEALTH_RECOVERING;
          recover_run_next  = '0;
          starve_run_next   = '0;
        end
      end else begin
        recover_run_next = '0;
      end
    end else begin
      starve_run_next = starving ? starve_inc : '0;
      if (starving && run_ge(starve_inc, regs.bypass_frames)) begin
        health_state_next = HEALTH_BYPASS;
      end else begin
        result_next.run_backend = 1'b1;
        if (!frame_in.solver_ok) begin
          health_state_next = HEALTH_WARMUP;
          degraded_run_next = '0;
          healthy_run_next  = '0;
        end else if (frame_in.state_nonfinite) begin
          result_next.restart_estimator = 1'b1;
          health_state_next = HEALTH_BYPASS;
        end else if (low_inliers || eig_degraded) begin
          degraded_run_next = degraded_inc;
          if (run_ge(degraded_inc, regs.hysteresis_frames)) begin
            health_state_next = HEALTH_DEGRADED;
            healthy_run_next  = '0;
          end
          if (eig_bypass) begin
            health_state_next = HEALTH_BYPASS;
          end
        end else begin
          healthy_run_next = healthy_inc;
          // Leaving degraded needs a full run of healthy frames.
          if (run_ge(healthy_inc, regs.hysteresis_frames) ||
              health_state != HEALTH_DEGRADED) begin
            health_state_next = HEALTH_ACTIVE;
          end
          degraded_run_next = '0;
        end
      end
    end

    result_next.health      = health_state_next;
    result_next.stale_total = stale_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      health_state  <= HEALTH_WARMUP;
      starve_run    <= '0;
      recover_run   <= '0;
      degraded_run  <= '0;
      healthy_run   <= '0;
      stale_counter <= '0;
    end else if (commit) begin
      health_state  <= health_state_next;
      starve_run    <= starve_run_next;
      recover_run   <= recover_run_next;
      degraded_run  <= degraded_run_next;
      healthy_run   <= healthy_run_next;
      stale_counter <= stale_counter_next;
    end
  end

endmodule

>>> hdl/tracker_health_supervisor_core.sv
// Tracker health supervisor. Each transfer on the frame channel carries one camera frame
// summary, and each frame gives exactly one transfer on the result channel, in order. A frame
// is registered on entry. When it moves on, the supervisor state and the result register are
// updated together. A new frame can be taken in every cycle while the result side keeps up.
// The result register lets the next frame enter while a result waits. Configuration writes
// take effect at once and are always accepted. They belong to idle periods only. Thresholds
// on run counters are compared with greater-or-equal against saturating 8-bit counts.
// Eigenvalues and their floors are unsigned Q16.16.
`include "tracker_health_supervisor_core_assert.svh"

module tracker_health_supervisor_core
  import ths_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ths_in_if.sink     frame,
  ths_out_if.source  result,
  ths_cfg_if.sink    cfg
);

  ths_cfg_t    regs;
  ths_frame_t  frame_reg;
  logic        frame_valid;
  ths_result_t result_next;
  ths_result_t result_reg;
  logic        result_valid;
  logic        advance;

  ths_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The registered frame moves on whenever the result register is free or being drained.
  assign advance     = !result_valid || result.ready;
  assign frame.ready = !frame_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame.ready) begin
      frame_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      frame_reg.frame_stale     <= frame.frame_stale;
      frame_reg.feature_count   <= frame.feature_count;
      frame_reg.solver_ok       <= frame.solver_ok;
      frame_reg.state_nonfinite <= frame.state_nonfinite;
      frame_reg.inlier_count    <= frame.inlier_count;
      frame_reg.min_eigen       <= frame.min_eigen;
    end
  end

  ths_supervisor u_supervisor (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .frame_in    (frame_reg),
    .commit      (frame_valid && advance),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && advance) begin
      result_reg <= result_next;
    end
  end

  assign result.valid             = result_valid;
  assign result.health            = result_reg.health;
  assign result.run_backend       = result_reg.run_backend;
  assign result.restart_estimator = result_reg.restart_estimator;
  assign result.dropped_stale     = result_reg.dropped_stale;
  assign result.stale_total       = result_reg.stale_total;

  `THS_ASSERT(a_stale_is_passive,
    result.valid && result.dropped_stale |-> !result.run_backend && !result.restart_estimator,
    "stale frame ran the backend or restarted the estimator")
  `THS_ASSERT(a_backend_restart_bypass,
    result.valid && result.run_backend && result.restart_estimator |->
      result.health == HEALTH_BYPASS,
    "backend restart without a move to bypass")
  `THS_ASSERT(a_bypass_restart_recover,
    result.valid && !result.run_backend && result.restart_estimator |->
      result.health == HEALTH_RECOVERING,
    "restart from bypass without a move to recovering")
  `THS_ASSERT_ALWAYS(a_stall_only_when_blocked,
    !rst && !frame.ready |-> result.valid && !result.ready,
    "frame input stalled while the result side was free")

endmodule

>>> sim/supervisor_checker.sv
`timescale 1ns / 100ps

module supervisor_checker
  import ths_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ths_in_if    frame,
  ths_out_if   result,
  ths_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);

  ths_cfg_t               regs;
  logic [HEALTH_BITS-1:0] health_st;
  logic [RUN_BITS-1:0]    starve_run;
  logic [RUN_BITS-1:0]    recover_run;
  logic [RUN_BITS-1:0]    degraded_run;
  logic [RUN_BITS-1:0]    healthy_run;
  logic [STALE_BITS-1:0]  stale_cnt;
  ths_result_t            predicted_status[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Moves the health machine by one frame and returns the status it reports.
  function automatic ths_result_t advance_supervisor(input ths_frame_t f);
    ths_result_t r;
    logic        to_bypass;
    r         = '0;
    to_bypass = 1'b0;
    if (f.frame_stale) begin
      if (stale_cnt != STALE_MAX) stale_cnt++;
      r.dropped_stale = 1'b1;
    end else if (health_st == HEALTH_BYPASS) begin
      if (f.feature_count >= regs.active_feature_floor) begin
        if (recover_run != RUN_MAX) recover_run++;
        if (recover_run >= regs.recovery_frames_needed) begin
          r.restart_estimator = 1'b1;
          health_st   = HEALTH_RECOVERING;
          recover_run = '0;
          starve_run  = '0;
        end
      end else begin
        recover_run = '0;
      end
    end else begin
      // Any frame at or above the starve floor ends a starvation run.
      if (f.feature_count < regs.starve_feature_floor) begin
        if (starve_run != RUN_MAX) starve_run++;
        if (starve_run >= regs.bypass_frames) to_bypass = 1'b1;
      end else begin
        starve_run = '0;
      end
      if (to_bypass) begin
        health_st = HEALTH_BYPASS;
      end else begin
        r.run_backend = 1'b1;
        if (!f.solver_ok) begin
          health_st    = HEALTH_WARMUP;
          degraded_run = '0;
          healthy_run  = '0;
        end else if (f.state_nonfinite) begin
          r.restart_estimator = 1'b1;
          health_st = HEALTH_BYPASS;
        end else if (f.inlier_count < regs.active_feature_floor ||
                     f.min_eigen < regs.degrade_eigen_floor) begin
          if (degraded_run != RUN_MAX) degraded_run++;
          if (degraded_run >= regs.hysteresis_frames) begin
            health_st   = HEALTH_DEGRADED;
            healthy_run = '0;
          end
          if (f.min_eigen < regs.bypass_eigen_floor) health_st = HEALTH_BYPASS;
        end else begin
          if (healthy_run != RUN_MAX) healthy_run++;
          if (healthy_run >= regs.hysteresis_frames || health_st != HEALTH_DEGRADED)
            health_st = HEALTH_ACTIVE;
          degraded_run = '0;
        end
      end
    end
    r.health      = health_st;
    r.stale_total = stale_cnt;
    return r;
  endfunction

  task automatic check_status(input ths_result_t got);
    ths_result_t want;
    if (predicted_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: health %0d backend %b restart %b",
                 $realtime, got.health, got.run_backend, got.restart_estimator);
    end else begin
      want = predicted_status[0];
      predicted_status.delete(0);
      if (got.health !== want.health || got.run_backend !== want.run_backend ||
          got.restart_estimator !== want.restart_estimator ||
          got.dropped_stale !== want.dropped_stale ||
          got.stale_total !== want.stale_total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected health %0d backend %b restart %b drop %b stale %0d",
                   $realtime, want.health, want.run_backend, want.restart_estimator,
                   want.dropped_stale, want.stale_total);
          $display("%0t: got      health %0d backend %b restart %b drop %b stale %0d",
                   $realtime, got.health, got.run_backend, got.restart_estimator,
                   got.dropped_stale, got.stale_total);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    ths_frame_t  f;
    ths_result_t got;
    if (rst) begin
      regs.active_feature_floor   = 12'd30;
      regs.starve_feature_floor   = 12'd10;
      regs.bypass_frames          = 8'd3;
      regs.recovery_frames_needed = 8'd5;
      regs.hysteresis_frames      = 8'd3;
      regs.degrade_eigen_floor    = 32'd65536;
      regs.bypass_eigen_floor     = 32'd6554;
      health_st    = HEALTH_WARMUP;
      starve_run   = '0;
      recover_run  = '0;
      degraded_run = '0;
      healthy_run  = '0;
      stale_cnt    = '0;
      predicted_status.delete();
    end else begin
      // A result can never belong to a frame taken at the same edge, so check it first.
      if (result.valid && result.ready) begin
        got.health            = result.health;
        got.run_backend       = result.run_backend;
        got.restart_estimator = result.restart_estimator;
        got.dropped_stale     = result.dropped_stale;
        got.stale_total       = result.stale_total;
        check_status(got);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ACTIVE_FEATURE_FLOOR:   regs.active_feature_floor = cfg.data[FEATURE_BITS-1:0];
          REG_STARVE_FEATURE_FLOOR:   regs.starve_feature_floor = cfg.data[FEATURE_BITS-1:0];
          REG_BYPASS_FRAMES:          regs.bypass_frames = cfg.data[THR_BITS-1:0];
          REG_RECOVERY_FRAMES_NEEDED: regs.recovery_frames_needed = cfg.data[THR_BITS-1:0];
          REG_HYSTERESIS_FRAMES:      regs.hysteresis_frames = cfg.data[THR_BITS-1:0];
          REG_DEGRADE_EIGEN_FLOOR:    regs.degrade_eigen_floor = cfg.data[EIGEN_BITS-1:0];
          REG_BYPASS_EIGEN_FLOOR:     regs.bypass_eigen_floor = cfg.data[EIGEN_BITS-1:0];
          default: ;
        endcase
      end
      if (frame.valid && frame.ready) begin
        f.frame_stale     = frame.frame_stale;
        f.feature_count   = frame.feature_count;
        f.solver_ok       = frame.solver_ok;
        f.state_nonfinite = frame.state_nonfinite;
        f.inlier_count    = frame.inlier_count;
        f.min_eigen       = frame.min_eigen;
        predicted_status.insert(predicted_status.size(), advance_supervisor(f));
      end
    end
    outstanding = predicted_status.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ths_pkg::*;

  typedef enum int {FEED_HEALTHY, FEED_WEAK, FEED_STARVED, FEED_NOISE} feed_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam int PHASE_FRAMES = 225;
  localparam int IDLE_PCT     = 38;
  localparam int FEAT_TOP     = (1 << FEATURE_BITS) - 1;

  logic  clk;
  logic  rst;
  int    mismatches;
  int    outstanding;
  bit    steady;
  bit    squeeze;
  feed_t feed;

  ths_in_if  frame_if();
  ths_out_if result_if();
  ths_cfg_if cfg_if();

  tracker_health_supervisor_core dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  supervisor_checker monitor_i (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame_if),
    .result      (result_if),
    .cfg         (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off so the block fills up.
  initial begin
    bit held;
    held = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        result_if.ready <= 1'b0;
        repeat (60) @(negedge clk);
      end
      result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [FEATURE_BITS-1:0] near_count(input logic [FEATURE_BITS-1:0] b);
    int off;
    int v;
    off = $urandom_range(0, 4);
    v   = int'(b) + off - 2;
    if (v < 0) v = 0;
    if (v > FEAT_TOP) v = FEAT_TOP;
    return FEATURE_BITS'(v);
  endfunction

  function automatic logic [EIGEN_BITS-1:0] near_eigen(input logic [EIGEN_BITS-1:0] b);
    longint off;
    longint v;
    off = $urandom_range(0, 6);
    v   = longint'(b) + off - 3;
    if (v < 0) v = 0;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return EIGEN_BITS'(v);
  endfunction

  function automatic logic [FEATURE_BITS-1:0] count_from(input logic [FEATURE_BITS-1:0] lo);
    return FEATURE_BITS'(lo + $urandom_range(0, FEAT_TOP - lo));
  endfunction

  function automatic logic [FEATURE_BITS-1:0] count_below(input logic [FEATURE_BITS-1:0] hi);
    return (hi == 0) ? '0 : FEATURE_BITS'($urandom_range(0, hi - 1));
  endfunction

  function automatic logic [EIGEN_BITS-1:0] eigen_from(input logic [EIGEN_BITS-1:0] lo);
    return lo + $urandom_range(0, 32'hFFFF_FFFF - lo);
  endfunction

  function automatic ths_frame_t make_frame(input feed_t fd, input ths_cfg_t c);
    ths_frame_t f;
    f.frame_stale     = ($urandom_range(99) < 6);
    f.solver_ok       = ($urandom_range(99) < 92);
    f.state_nonfinite = ($urandom_range(99) < 4);
    case (fd)
      FEED_HEALTHY: begin
        f.feature_count = $urandom_range(1) ? near_count(c.active_feature_floor)
                                            : count_from(c.active_feature_floor);
        f.inlier_count  = $urandom_range(3) ? count_from(c.active_feature_floor)
                                            : near_count(c.active_feature_floor);
        f.min_eigen     = $urandom_range(3) ? eigen_from(c.degrade_eigen_floor)
                                            : near_eigen(c.degrade_eigen_floor);
      end
      FEED_WEAK: begin
        f.feature_count = count_from(c.starve_feature_floor);
        f.inlier_count  = $urandom_range(1) ? count_below(c.active_feature_floor)
                                            : near_count(c.active_feature_floor);
        case ($urandom_range(2))
          0: f.min_eigen = near_eigen(c.bypass_eigen_floor);
          1: f.min_eigen = near_eigen(c.degrade_eigen_floor);
          default: begin
            if (c.degrade_eigen_floor >= c.bypass_eigen_floor)
              f.min_eigen = c.bypass_eigen_floor +
                            $urandom_range(0, c.degrade_eigen_floor - c.bypass_eigen_floor);
            else
              f.min_eigen = $urandom_range(0, c.degrade_eigen_floor);
          end
        endcase
      end
      FEED_STARVED: begin
        f.feature_count = $urandom_range(1) ? count_below(c.starve_feature_floor)
                                            : near_count(c.starve_feature_floor);
        f.inlier_count  = FEATURE_BITS'($urandom());
        f.min_eigen     = $urandom();
      end
      default: begin
        f.frame_stale     = 1'($urandom_range(1));
        f.solver_ok       = 1'($urandom_range(1));
        f.state_nonfinite = 1'($urandom_range(1));
        f.feature_count   = FEATURE_BITS'($urandom());
        f.inlier_count    = FEATURE_BITS'($urandom());
        f.min_eigen       = $urandom();
      end
    endcase
    return f;
  endfunction

  function automatic ths_cfg_t rand_settings();
    ths_cfg_t c;
    c.active_feature_floor   = FEATURE_BITS'($urandom_range(0, 300));
    c.starve_feature_floor   = FEATURE_BITS'($urandom_range(0, 120));
    c.bypass_frames          = THR_BITS'($urandom_range(0, 6));
    c.recovery_frames_needed = THR_BITS'($urandom_range(0, 8));
    c.hysteresis_frames      = THR_BITS'($urandom_range(0, 5));
    c.degrade_eigen_floor    = $urandom_range(0, 300000);
    c.bypass_eigen_floor     = $urandom_range(0, c.degrade_eigen_floor);
    return c;
  endfunction

  // Keeps the register value in the low bits and fills the rest with junk.
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(input logic [CFG_DATA_BITS-1:0] v,
                                                         input int w);
    logic [CFG_DATA_BITS-1:0] mask;
    mask = (w >= CFG_DATA_BITS) ? '1 : ((32'd1 << w) - 1);
    return ($urandom() & ~mask) | (v & mask);
  endfunction

  task automatic push_frame(input ths_frame_t f);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      frame_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    frame_if.valid           <= 1'b1;
    frame_if.frame_stale     <= f.frame_stale;
    frame_if.feature_count   <= f.feature_count;
    frame_if.solver_ok       <= f.solver_ok;
    frame_if.state_nonfinite <= f.state_nonfinite;
    frame_if.inlier_count    <= f.inlier_count;
    frame_if.min_eigen       <= f.min_eigen;
    do begin
      @(posedge clk);
    end while (!frame_if.ready);
    @(negedge clk);
  endtask

  task automatic push_fields(input int stale, input int feats, input int ok, input int nf,
                             input int inl, input logic [EIGEN_BITS-1:0] eig);
    ths_frame_t f;
    f.frame_stale     = 1'(stale);
    f.feature_count   = FEATURE_BITS'(feats);
    f.solver_ok       = 1'(ok);
    f.state_nonfinite = 1'(nf);
    f.inlier_count    = FEATURE_BITS'(inl);
    f.min_eigen       = eig;
    push_frame(f);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input ths_cfg_t c);
    write_reg(REG_ACTIVE_FEATURE_FLOOR,
              with_junk(CFG_DATA_BITS'(c.active_feature_floor), FEATURE_BITS));
    write_reg(REG_STARVE_FEATURE_FLOOR,
              with_junk(CFG_DATA_BITS'(c.starve_feature_floor), FEATURE_BITS));
    write_reg(REG_BYPASS_FRAMES, with_junk(CFG_DATA_BITS'(c.bypass_frames), THR_BITS));
    write_reg(REG_UNUSED, $urandom());
    write_reg(REG_RECOVERY_FRAMES_NEEDED,
              with_junk(CFG_DATA_BITS'(c.recovery_frames_needed), THR_BITS));
    write_reg(REG_HYSTERESIS_FRAMES,
              with_junk(CFG_DATA_BITS'(c.hysteresis_frames), THR_BITS));
    write_reg(REG_DEGRADE_EIGEN_FLOOR, c.degrade_eigen_floor);
    write_reg(REG_BYPASS_EIGEN_FLOOR, c.bypass_eigen_floor);
    cfg_if.valid <= 1'b0;
  endtask

  // Every frame yields a result, so once nothing is pending the block is idle.
  task automatic drain();
    frame_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    ths_cfg_t c;
    rst                      = 1'b1;
    steady                   = 1'b0;
    squeeze                  = 1'b0;
    feed                     = FEED_HEALTHY;
    frame_if.valid           = 1'b0;
    frame_if.frame_stale     = 1'b0;
    frame_if.feature_count   = '0;
    frame_if.solver_ok       = 1'b0;
    frame_if.state_nonfinite = 1'b0;
    frame_if.inlier_count    = '0;
    frame_if.min_eigen       = '0;
    cfg_if.valid             = 1'b0;
    cfg_if.index             = REG_ACTIVE_FEATURE_FLOOR;
    cfg_if.data              = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass on the reset settings.
    push_fields(0, 100, 0, 1, 100, 32'h0001_0000);   // solver failed, nonfinite ignored
    push_fields(0, 4095, 1, 0, 4095, 32'hFFFF_FFFF);  // healthy frame
    push_fields(1, 4095, 1, 1, 4095, 32'hFFFF_FFFF);  // stale frame is dropped
    repeat (3) push_fields(0, 50, 1, 0, 5, 32'h0002_0000);
    repeat (3) push_fields(0, 50, 1, 0, 50, 32'h0002_0000);
    push_fields(0, 50, 1, 0, 50, 32'h0000_1000);      // below the bypass floor
    push_fields(0, 30, 0, 1, 0, 32'h0);                // bypass ignores the backend
    push_fields(0, 30, 1, 0, 0, 32'h0);
    push_fields(0, 29, 1, 0, 4095, 32'hFFFF_FFFF);    // breaks the recovery run
    repeat (5) push_fields(0, 30, 1, 0, 0, 32'h0);
    push_fields(0, 40, 1, 1, 40, 32'hFFFF_FFFF);      // nonfinite state
    repeat (5) push_fields(0, 4095, 0, 0, 0, 32'h0);
    push_fields(0, 0, 1, 0, 4095, 32'hFFFF_FFFF);     // starving, backend still runs
    push_fields(0, 9, 1, 0, 4095, 32'hFFFF_FFFF);
    push_fields(0, 9, 1, 0, 0, 32'h0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: c = '0;
        1: c = '1;
        2: begin
          c.active_feature_floor   = 12'd30;
          c.starve_feature_floor   = 12'd10;
          c.bypass_frames          = 8'd3;
          c.recovery_frames_needed = 8'd5;
          c.hysteresis_frames      = 8'd3;
          c.degrade_eigen_floor    = 32'd65536;
          c.bypass_eigen_floor     = 32'd6554;
        end
        default: c = rand_settings();
      endcase
      program_regs(c);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        steady = (ph == 2 && n < 150);
        if (ph == 4 && n == 40) squeeze = 1'b1;
        if ($urandom_range(7) == 0) feed = feed_t'($urandom_range(3));
        push_frame(make_frame(feed, c));
      end
    end

    frame_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
